[sv/amsdu_deaggregator_unit_macros.svh]
// assertion macros for the a-msdu deaggregator
// used by the top level only; no dependencies
`ifndef AMSDU_DEAGGREGATOR_UNIT_MACROS_SVH
`define AMSDU_DEAGGREGATOR_UNIT_MACROS_SVH

// same-cycle implication
`define AMSDU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMSDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/amsdu_dagg_pkg.sv]
// shared types and constants of the a-msdu deaggregator
// no dependencies
package amsdu_dagg_pkg;

   localparam int ADDRESS_BYTES  = 6;
   localparam int ADDR_TOTAL     = 2 * ADDRESS_BYTES;
   localparam int HDR_BYTES      = 14;
   localparam int LLC_SNAP_BYTES = 8;
   localparam int DROP_BYTES     = 6;
   localparam int BODY_START     = HDR_BYTES + DROP_BYTES;
   localparam int ADDR_IDX_W     = $clog2(ADDR_TOTAL);
   localparam int OFFSET_W       = $clog2(BODY_START + 1);
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SUBFRAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SUBFRAME_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_REMAINING_BYTES = 2'd2;

   localparam logic [15:0] RESET_MAX_SUBFRAME_LENGTH = 16'd1508;
   localparam logic [15:0] RESET_MIN_SUBFRAME_LENGTH = 16'd54;
   localparam logic [15:0] RESET_MIN_REMAINING_BYTES = 16'd68;

   localparam logic [1:0] RES_NONE   = 2'd0;
   localparam logic [1:0] RES_SINGLE = 2'd1;
   localparam logic [1:0] RES_BURST  = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        aggregate_start;
      logic [13:0] total_length;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_first;
      logic       frame_last;
      logic       length_error;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_subframe_length;
      logic [15:0] min_subframe_length;
      logic [15:0] min_remaining_bytes;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      rsp_type    beat;
   } result_type;

   typedef struct packed {
      logic can_take;
      logic burst_active;
   } out_status_type;

endpackage

[sv/amsdu_dagg_if.sv]
// channel interfaces of the a-msdu deaggregator: request, response, csr write
// depends on amsdu_dagg_pkg
interface amsdu_dagg_req_if;
   logic                     valid;
   logic                     ready;
   amsdu_dagg_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface amsdu_dagg_rsp_if;
   logic                     valid;
   logic                     ready;
   amsdu_dagg_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface amsdu_dagg_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [amsdu_dagg_pkg::CSR_INDEX_W-1:0]  index;
   logic [15:0]                             data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/amsdu_dagg_parse.sv]
// subframe parser: per-byte state machine, address buffer and length checks
// depends on amsdu_dagg_pkg
module amsdu_dagg_parse #(
   parameter int MAX_AGGREGATE_BYTES = 16383
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    fire,
   input  amsdu_dagg_pkg::req_type                 item,
   input  amsdu_dagg_pkg::cfg_type                 cfg,
   input  logic [amsdu_dagg_pkg::ADDR_IDX_W-1:0]   rd_index,
   output logic [7:0]                              rd_byte,
   output amsdu_dagg_pkg::result_type              result
);

   localparam int RW = $clog2(MAX_AGGREGATE_BYTES + 1);
   localparam int CW = 18;
   localparam int OW = amsdu_dagg_pkg::OFFSET_W;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_BODY    = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   logic [1:0]    phase_ff, phase_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic [15:0]   length_ff, length_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic [1:0]    pad_ff, pad_in;
   logic          wr_en;
   logic [amsdu_dagg_pkg::ADDR_IDX_W-1:0] wr_index;
   logic [7:0]    addr_buf_ff [amsdu_dagg_pkg::ADDR_TOTAL];

   always_comb begin
      logic [RW-1:0] total_clamped;
      logic [RW-1:0] rem0;
      logic [1:0]    phase0;
      logic [OW-1:0] off0;
      logic [15:0]   len0;
      logic [1:0]    pad0;
      logic [RW-1:0] rem_dec;
      logic          last_byte;
      logic [15:0]   len_full;
      logic [15:0]   len_dec;
      logic [CW-1:0] start_rem;
      logic [CW-1:0] sub_len;
      logic          bad_len;

      total_clamped = ({3'b000, item.total_length} > 17'(MAX_AGGREGATE_BYTES))
                    ? RW'(MAX_AGGREGATE_BYTES) : RW'(item.total_length);
      rem0   = item.aggregate_start ? total_clamped : remain_ff;
      phase0 = item.aggregate_start ? ((total_clamped == '0) ? PH_IDLE : PH_HEADER)
                                    : phase_ff;
      off0   = item.aggregate_start ? '0 : offset_ff;
      len0   = item.aggregate_start ? '0 : length_ff;
      pad0   = item.aggregate_start ? '0 : pad_ff;

      wr_index  = off0[amsdu_dagg_pkg::ADDR_IDX_W-1:0];
      rem_dec   = rem0 - RW'(1);
      last_byte = (rem0 == RW'(1));
      len_full  = {len0[15:8], item.data_byte};
      len_dec   = len0 - 16'd1;
      start_rem = CW'(rem0) + CW'(amsdu_dagg_pkg::HDR_BYTES - 1);
      sub_len   = CW'(len_full) + CW'(amsdu_dagg_pkg::HDR_BYTES);
      bad_len   = (len_full > cfg.max_subframe_length)
               || (len_full < cfg.min_subframe_length)
               || (len_full < 16'(amsdu_dagg_pkg::LLC_SNAP_BYTES))
               || (sub_len > start_rem)
               || (start_rem < CW'(cfg.min_remaining_bytes));

      phase_in  = phase0;
      offset_in = off0;
      length_in = len0;
      remain_in = rem0;
      pad_in    = pad0;
      wr_en     = 1'b0;
      result    = '0;

      if (phase0 == PH_IDLE || rem0 == '0) begin
         phase_in = PH_IDLE;
      end else begin
         remain_in = rem_dec;
         unique case (phase0)
            PH_HEADER: begin
               priority if (pad0 != 2'd0) begin
                  pad_in = pad0 - 2'd1;
               end else if (off0 < OW'(amsdu_dagg_pkg::ADDR_TOTAL)) begin
                  wr_en     = 1'b1;
                  offset_in = off0 + OW'(1);
                  if (last_byte) begin
                     result.kind              = amsdu_dagg_pkg::RES_SINGLE;
                     result.beat.length_error = 1'b1;
                     result.beat.run_last     = 1'b1;
                  end
               end else if (off0 == OW'(amsdu_dagg_pkg::ADDR_TOTAL)) begin
                  length_in = {item.data_byte, 8'h00};
                  offset_in = off0 + OW'(1);
                  if (last_byte) begin
                     result.kind              = amsdu_dagg_pkg::RES_SINGLE;
                     result.beat.length_error = 1'b1;
                     result.beat.run_last     = 1'b1;
                  end
               end else begin
                  if (bad_len) begin
                     result.kind              = amsdu_dagg_pkg::RES_SINGLE;
                     result.beat.length_error = 1'b1;
                     result.beat.run_last     = 1'b1;
                     phase_in                 = PH_DISCARD;
                  end else begin
                     result.kind = amsdu_dagg_pkg::RES_BURST;
                     length_in   = len_full - 16'(amsdu_dagg_pkg::DROP_BYTES);
                     offset_in   = OW'(amsdu_dagg_pkg::HDR_BYTES);
                     pad_in      = (start_rem == sub_len) ? 2'd0 : 2'(-sub_len[1:0]);
                     phase_in    = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (off0 < OW'(amsdu_dagg_pkg::BODY_START)) begin
                  offset_in = off0 + OW'(1);
               end else begin
                  length_in              = len_dec;
                  result.kind            = amsdu_dagg_pkg::RES_SINGLE;
                  result.beat.frame_byte = item.data_byte;
                  result.beat.frame_last = (len_dec == 16'd0);
                  result.beat.run_last   = 1'b1;
                  if (len_dec == 16'd0) begin
                     phase_in  = PH_HEADER;
                     offset_in = '0;
                  end
               end
            end
            PH_DISCARD: begin
               phase_in = PH_DISCARD;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (rem_dec == '0) begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         offset_ff <= '0;
         length_ff <= '0;
         remain_ff <= '0;
         pad_ff    <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         addr_buf_ff[wr_index] <= item.data_byte;
      end
   end

   assign rd_byte = addr_buf_ff[rd_index];

endmodule

[sv/amsdu_dagg_out.sv]
// result register with address burst counter feeding the response channel
// depends on amsdu_dagg_pkg and amsdu_dagg_rsp_if
module amsdu_dagg_out (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    fire,
   input  amsdu_dagg_pkg::result_type              result,
   input  logic [7:0]                              rd_byte,
   output logic [amsdu_dagg_pkg::ADDR_IDX_W-1:0]   rd_index,
   output amsdu_dagg_pkg::out_status_type          status,
   amsdu_dagg_rsp_if.source                        rsp_if
);

   localparam int IW = amsdu_dagg_pkg::ADDR_IDX_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(amsdu_dagg_pkg::ADDR_TOTAL - 1);

   logic                     valid_ff, valid_in;
   amsdu_dagg_pkg::rsp_type  data_ff, data_in;
   logic                     burst_ff, burst_in;
   logic [IW-1:0]            cnt_ff, cnt_in;

   assign status.burst_active = burst_ff;
   assign status.can_take     = !valid_ff || (rsp_if.ready && !burst_ff);
   assign rd_index            = burst_ff ? cnt_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      burst_in = burst_ff;
      cnt_in   = cnt_ff;
      priority if (fire && result.kind != amsdu_dagg_pkg::RES_NONE) begin
         valid_in = 1'b1;
         if (result.kind == amsdu_dagg_pkg::RES_BURST) begin
            data_in             = '0;
            data_in.frame_byte  = rd_byte;
            data_in.frame_first = 1'b1;
            burst_in            = 1'b1;
            cnt_in              = IW'(1);
         end else begin
            data_in = result.beat;
         end
      end else if (valid_ff && rsp_if.ready) begin
         if (burst_ff) begin
            data_in            = '0;
            data_in.frame_byte = rd_byte;
            data_in.run_last   = (cnt_ff == LAST_IDX);
            cnt_in             = cnt_ff + IW'(1);
            if (cnt_ff == LAST_IDX) begin
               burst_in = 1'b0;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         burst_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         burst_ff <= burst_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = data_ff;

endmodule

[sv/amsdu_deaggregator_unit.sv]
// a-msdu deaggregator top level: input register, csr registers, parser, result stage
// depends on amsdu_dagg_pkg, the channel interfaces, amsdu_dagg_parse, amsdu_dagg_out and the assertion macros
//
// usage: req_if carries one aggregate byte per beat, aggregate_start and
// total_length marking the first byte after the signal header. rsp_if gives
// ethernet frame bytes with first/last flags, or one length_error beat per
// bad subframe; run_last marks the last beat caused by one request beat.
// csr_if writes the three length limits; it is always ready.
// path: a request beat is held in the input register, its result in the result register.
// throughput: one byte per cycle while rsp_if is ready; the second length byte of a
// good subframe releases the 12 address bytes from the address buffer one per
// cycle while rsp_if is ready, and holds the input register until the last is taken.
// a stalled rsp_if holds the result register; an empty input register still
// takes one more beat, then req_if.ready drops.
// reset (synchronous) returns the parser to idle and restores default limits.
module amsdu_deaggregator_unit #(
   parameter int MAX_AGGREGATE_BYTES = 16383
) (
   input  logic             clock,
   input  logic             reset,
   amsdu_dagg_req_if.sink   req_if,
   amsdu_dagg_rsp_if.source rsp_if,
   amsdu_dagg_csr_if.sink   csr_if
);

`include "amsdu_deaggregator_unit_macros.svh"

   logic                                          in_valid_ff;
   amsdu_dagg_pkg::req_type                       item_ff;
   amsdu_dagg_pkg::cfg_type                       cfg_ff;
   logic                                          fire;
   amsdu_dagg_pkg::result_type                    result;
   amsdu_dagg_pkg::out_status_type                status;
   logic [amsdu_dagg_pkg::ADDR_IDX_W-1:0]         rd_index;
   logic [7:0]                                    rd_byte;

   assign fire          = in_valid_ff && status.can_take;
   assign req_if.ready  = !in_valid_ff || fire;
   assign csr_if.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff <= req_if.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_subframe_length <= amsdu_dagg_pkg::RESET_MAX_SUBFRAME_LENGTH;
         cfg_ff.min_subframe_length <= amsdu_dagg_pkg::RESET_MIN_SUBFRAME_LENGTH;
         cfg_ff.min_remaining_bytes <= amsdu_dagg_pkg::RESET_MIN_REMAINING_BYTES;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            amsdu_dagg_pkg::REG_MAX_SUBFRAME_LENGTH: cfg_ff.max_subframe_length <= csr_if.data;
            amsdu_dagg_pkg::REG_MIN_SUBFRAME_LENGTH: cfg_ff.min_subframe_length <= csr_if.data;
            amsdu_dagg_pkg::REG_MIN_REMAINING_BYTES: cfg_ff.min_remaining_bytes <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   amsdu_dagg_parse #(
      .MAX_AGGREGATE_BYTES (MAX_AGGREGATE_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item_ff),
      .cfg      (cfg_ff),
      .rd_index (rd_index),
      .rd_byte  (rd_byte),
      .result   (result)
   );

   amsdu_dagg_out u_out (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .result   (result),
      .rd_byte  (rd_byte),
      .rd_index (rd_index),
      .status   (status),
      .rsp_if   (rsp_if)
   );

   `AMSDU_ASSERT_NOW(a_burst_has_beat, clock, reset, status.burst_active, rsp_if.valid, "burst without beat")
   `AMSDU_ASSERT_NOW(a_no_fire_in_burst, clock, reset, status.burst_active, !fire, "parser fired during burst")
   `AMSDU_ASSERT_NOW(a_first_not_error, clock, reset, rsp_if.valid, !(rsp_if.payload.frame_first && rsp_if.payload.length_error), "error beat flagged first")
   `AMSDU_ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && !fire, in_valid_ff, "input item lost")

endmodule

[tb/tb_top.sv]
// self-checking testbench for amsdu_deaggregator_unit: byte stimulus, csr limit
// settings, a predictor of the frame beats and a beat-by-beat scoreboard
// depends on amsdu_dagg_pkg, the channel interfaces and amsdu_deaggregator_unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AGGREGATE_LIMIT = 16383;

   typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_BODY, PARSE_DISCARD}
      parse_state_type;
   typedef enum logic [1:0] {BY_MODEL, NO_RESULT, LEN_ERROR} check_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        start;
      logic [13:0] total;
      check_type   kind;
   } dir_row_type;

   typedef struct {
      amsdu_dagg_pkg::req_type req;
      check_type               kind;
   } plan_beat_type;

   localparam amsdu_dagg_pkg::rsp_type ERROR_BEAT = '{frame_byte: 8'h00, frame_first: 1'b0,
                                                     frame_last: 1'b0, length_error: 1'b1,
                                                     run_last: 1'b1};

   localparam dir_row_type DIRECTED_ROWS [23] = '{
      '{8'h00, 1'b0, 14'd0,     NO_RESULT},
      '{8'hFF, 1'b0, 14'h3FFF,  NO_RESULT},
      '{8'hA5, 1'b1, 14'd0,     NO_RESULT},
      '{8'hFF, 1'b1, 14'd1,     LEN_ERROR},
      '{8'h00, 1'b1, 14'd2,     NO_RESULT},
      '{8'h80, 1'b0, 14'd0,     LEN_ERROR},
      '{8'h11, 1'b1, 14'd16383, NO_RESULT},
      '{8'h22, 1'b0, 14'h3FFF,  NO_RESULT},
      '{8'h01, 1'b1, 14'd16383, BY_MODEL},
      '{8'h02, 1'b0, 14'd0,     BY_MODEL},
      '{8'h04, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'h08, 1'b0, 14'd0,     BY_MODEL},
      '{8'h10, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'h20, 1'b0, 14'd0,     BY_MODEL},
      '{8'h40, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'h80, 1'b0, 14'd0,     BY_MODEL},
      '{8'hFE, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'hFD, 1'b0, 14'd0,     BY_MODEL},
      '{8'hFB, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'hF7, 1'b0, 14'd0,     BY_MODEL},
      '{8'hFF, 1'b0, 14'h3FFF,  BY_MODEL},
      '{8'hFF, 1'b0, 14'd0,     LEN_ERROR},
      '{8'h5A, 1'b0, 14'h3FFF,  NO_RESULT}
   };

   logic clock;
   logic reset;

   amsdu_dagg_req_if req_if ();
   amsdu_dagg_rsp_if rsp_if ();
   amsdu_dagg_csr_if csr_if ();

   amsdu_deaggregator_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // predictor state
   logic [7:0]      addr_mem [amsdu_dagg_pkg::ADDR_TOTAL];
   logic [10:0]     sf_offset;
   logic [15:0]     sf_len;
   logic [13:0]     remaining;
   logic [1:0]      pad_left;
   parse_state_type parse_state;
   logic [15:0]     lim_max;
   logic [15:0]     lim_min;
   logic [15:0]     lim_rem;

   amsdu_dagg_pkg::rsp_type step_out [$];
   amsdu_dagg_pkg::rsp_type frames_due [$];
   plan_beat_type           byte_plan [$];
   plan_beat_type           cur_beat;
   bit                      req_taken;
   int                      beats_planned;
   int                      req_accepted;
   int                      beats_seen;
   int                      mismatches;
   int                      hold_left;
   bit                      held_once;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void reset_model();
      foreach (addr_mem[i]) addr_mem[i] = 8'h00;
      sf_offset   = '0;
      sf_len      = '0;
      remaining   = '0;
      pad_left    = '0;
      parse_state = PARSE_IDLE;
      lim_max     = amsdu_dagg_pkg::RESET_MAX_SUBFRAME_LENGTH;
      lim_min     = amsdu_dagg_pkg::RESET_MIN_SUBFRAME_LENGTH;
      lim_rem     = amsdu_dagg_pkg::RESET_MIN_REMAINING_BYTES;
   endfunction

   function automatic void queue_beat(logic [7:0] b, logic first, logic last, logic err);
      amsdu_dagg_pkg::rsp_type beat;
      beat.frame_byte   = b;
      beat.frame_first  = first;
      beat.frame_last   = last;
      beat.length_error = err;
      beat.run_last     = 1'b0;
      step_out.push_back(beat);
   endfunction

   function automatic void deaggregate_byte(amsdu_dagg_pkg::req_type r);
      logic [13:0] rem_now;
      logic [16:0] start_rem;
      logic [16:0] sub;
      logic [15:0] len;
      logic        last_byte;
      step_out.delete();
      if (r.aggregate_start) begin
         remaining   = (r.total_length > 14'(AGGREGATE_LIMIT)) ? 14'(AGGREGATE_LIMIT)
                                                               : r.total_length;
         parse_state = (remaining == '0) ? PARSE_IDLE : PARSE_HEADER;
         sf_offset   = '0;
         sf_len      = '0;
         pad_left    = '0;
      end
      if (parse_state == PARSE_IDLE || remaining == '0) begin
         parse_state = PARSE_IDLE;
         return;
      end
      rem_now   = remaining;
      last_byte = (remaining == 14'd1);
      remaining = remaining - 14'd1;
      case (parse_state)
         PARSE_HEADER: begin
            if (pad_left != 2'd0) begin
               pad_left = pad_left - 2'd1;
            end else if (sf_offset < 11'(amsdu_dagg_pkg::ADDR_TOTAL)) begin
               addr_mem[sf_offset[amsdu_dagg_pkg::ADDR_IDX_W-1:0]] = r.data_byte;
               sf_offset = sf_offset + 11'd1;
               if (last_byte) queue_beat(8'h00, 1'b0, 1'b0, 1'b1);
            end else if (sf_offset == 11'(amsdu_dagg_pkg::ADDR_TOTAL)) begin
               sf_len    = {r.data_byte, 8'h00};
               sf_offset = sf_offset + 11'd1;
               if (last_byte) queue_beat(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
               len       = sf_len | {8'h00, r.data_byte};
               start_rem = 17'(rem_now) + 17'(amsdu_dagg_pkg::HDR_BYTES - 1);
               sub       = 17'(len) + 17'(amsdu_dagg_pkg::HDR_BYTES);
               if (len > lim_max || len < lim_min ||
                   len < 16'(amsdu_dagg_pkg::LLC_SNAP_BYTES) ||
                   sub > start_rem || start_rem < 17'(lim_rem)) begin
                  queue_beat(8'h00, 1'b0, 1'b0, 1'b1);
                  parse_state = PARSE_DISCARD;
               end else begin
                  for (int i = 0; i < amsdu_dagg_pkg::ADDR_TOTAL; i++) begin
                     queue_beat(addr_mem[i], i == 0, 1'b0, 1'b0);
                  end
                  sf_len      = len - 16'(amsdu_dagg_pkg::DROP_BYTES);
                  sf_offset   = 11'(amsdu_dagg_pkg::HDR_BYTES);
                  pad_left    = (start_rem == sub) ? 2'd0 : 2'(17'd0 - sub);
                  parse_state = PARSE_BODY;
               end
            end
         end
         PARSE_BODY: begin
            if (sf_offset < 11'(amsdu_dagg_pkg::BODY_START)) begin
               sf_offset = sf_offset + 11'd1;
            end else begin
               sf_len = sf_len - 16'd1;
               queue_beat(r.data_byte, 1'b0, sf_len == '0, 1'b0);
               if (sf_len == '0) begin
                  parse_state = PARSE_HEADER;
                  sf_offset   = '0;
               end
            end
         end
         default: ;
      endcase
      if (remaining == '0) parse_state = PARSE_IDLE;
      if (step_out.size() != 0) step_out[step_out.size() - 1].run_last = 1'b1;
   endfunction

   function automatic bit idle_now();
      if (req_accepted >= 140 && req_accepted < 200) return 1'b0;
      return $urandom_range(0, 99) < 28;
   endfunction

   // request side: a beat stays offered until taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 1'b0;
         if (byte_plan.size() != 0 && !idle_now()) begin
            cur_beat = byte_plan.pop_front();
            req_if.valid   <= 1'b1;
            req_if.payload <= cur_beat.req;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response side, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!held_once && req_accepted >= 40 && byte_plan.size() >= 24) begin
            hold_left = 300;
            held_once = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !idle_now();
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      amsdu_dagg_pkg::rsp_type due;
      amsdu_dagg_pkg::rsp_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            req_accepted++;
            deaggregate_byte(cur_beat.req);
            if (cur_beat.kind == BY_MODEL) begin
               foreach (step_out[i]) frames_due.push_back(step_out[i]);
            end else if (cur_beat.kind == LEN_ERROR) begin
               frames_due.push_back(ERROR_BEAT);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            beats_seen++;
            got = rsp_if.payload;
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got byte %h first %b last %b",
                        $time, got.frame_byte, got.frame_first, got.frame_last,
                        " err %b run_last %b", got.length_error, got.run_last);
               mismatches++;
            end else begin
               due = frames_due.pop_front();
               if (got.frame_byte !== due.frame_byte || got.frame_first !== due.frame_first ||
                   got.frame_last !== due.frame_last || got.length_error !== due.length_error ||
                   got.run_last !== due.run_last) begin
                  $display("%0t: beat mismatch: expected byte %h first %b last %b err %b",
                           $time, due.frame_byte, due.frame_first, due.frame_last,
                           due.length_error, " run_last %b, got byte %h first %b last %b",
                           due.run_last, got.frame_byte, got.frame_first, got.frame_last,
                           " err %b run_last %b", got.length_error, got.run_last);
                  mismatches++;
               end
            end
         end
      end
   end

   function automatic void plan_beat(logic [7:0] d, logic s, logic [13:0] t, check_type kind);
      plan_beat_type pb;
      pb.req.data_byte       = d;
      pb.req.aggregate_start = s;
      pb.req.total_length    = t;
      pb.kind                = kind;
      byte_plan.push_back(pb);
      beats_planned++;
   endfunction

   function automatic int pick_length();
      int lo;
      int hi;
      lo = (lim_min > 16'd8) ? int'(lim_min) : 8;
      hi = (int'(lim_max) < lo + 12) ? int'(lim_max) : lo + 12;
      if (lo > hi) return $urandom_range(8, 40);
      if ($urandom_range(0, 9) == 0) return hi;
      return $urandom_range(lo, hi);
   endfunction

   task automatic plan_aggregate(output int used);
      logic [7:0]  agg [$];
      logic [15:0] len_field;
      int pick;
      int n_sub;
      int len;
      int pad;
      int total;
      int sent;
      int k;
      used = 0;
      pad  = 0;
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
         k = $urandom_range(1, 4);
         repeat (k) begin
            plan_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      14'($urandom_range(0, 16383)), BY_MODEL);
         end
         used = k;
         return;
      end
      n_sub = $urandom_range(1, 2);
      for (int s = 0; s < n_sub; s++) begin
         len       = pick_length();
         len_field = 16'(len);
         if (pick >= 80 && s == 0) begin
            len_field = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                             : 16'($urandom_range(0, 65535));
         end
         repeat (amsdu_dagg_pkg::ADDR_TOTAL) agg.push_back(8'($urandom_range(0, 255)));
         agg.push_back(len_field[15:8]);
         agg.push_back(len_field[7:0]);
         repeat (len) agg.push_back(8'($urandom_range(0, 255)));
         pad = (4 - ((len + amsdu_dagg_pkg::HDR_BYTES) % 4)) % 4;
         if (s != n_sub - 1) repeat (pad) agg.push_back(8'($urandom_range(0, 255)));
      end
      total = agg.size();
      sent  = total;
      if (pick >= 70 && pick < 80) begin
         case ($urandom_range(0, 2))
            0: begin
               total = $urandom_range(1, agg.size() - 1);
               sent  = total;
            end
            1: begin
               k = (pad != 0) ? $urandom_range(1, pad) : $urandom_range(1, 3);
               repeat (k) agg.push_back(8'($urandom_range(0, 255)));
               total = agg.size();
               sent  = total;
            end
            default: sent = $urandom_range(1, agg.size() - 1);
         endcase
      end
      for (int i = 0; i < sent; i++) begin
         plan_beat(agg[i], i == 0, (i == 0) ? 14'(total) : 14'($urandom_range(0, 16383)),
                   BY_MODEL);
      end
      used = sent;
   endtask

   task automatic plan_phase(input int budget);
      int planned;
      int used;
      planned = 0;
      while (planned < budget) begin
         plan_aggregate(used);
         planned += used;
      end
   endtask

   task automatic write_limit(input logic [amsdu_dagg_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [15:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         amsdu_dagg_pkg::REG_MAX_SUBFRAME_LENGTH: lim_max = value;
         amsdu_dagg_pkg::REG_MIN_SUBFRAME_LENGTH: lim_min = value;
         amsdu_dagg_pkg::REG_MIN_REMAINING_BYTES: lim_rem = value;
         default: ;
      endcase
   endtask

   task automatic set_limits(input logic [15:0] max_len, input logic [15:0] min_len,
                             input logic [15:0] min_rem);
      write_limit(amsdu_dagg_pkg::REG_MAX_SUBFRAME_LENGTH, max_len);
      write_limit(amsdu_dagg_pkg::REG_MIN_SUBFRAME_LENGTH, min_len);
      write_limit(amsdu_dagg_pkg::REG_MIN_REMAINING_BYTES, min_rem);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      while (req_accepted != beats_planned || frames_due.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = amsdu_dagg_pkg::REG_MAX_SUBFRAME_LENGTH;
      csr_if.data    = '0;
      req_taken      = 1'b0;
      beats_planned  = 0;
      req_accepted   = 0;
      beats_seen     = 0;
      mismatches     = 0;
      hold_left      = 0;
      held_once      = 1'b0;
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         plan_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].total,
                   DIRECTED_ROWS[i].kind);
      end
      drain();

      set_limits(16'hFFFF, 16'h0000, 16'h0000);
      plan_phase(20);
      drain();
      set_limits(16'd30, 16'd8, 16'd22);
      plan_phase(20);
      drain();
      set_limits(amsdu_dagg_pkg::RESET_MAX_SUBFRAME_LENGTH,
                 amsdu_dagg_pkg::RESET_MIN_SUBFRAME_LENGTH,
                 amsdu_dagg_pkg::RESET_MIN_REMAINING_BYTES);
      plan_phase(20);
      drain();
      set_limits(16'h0000, 16'hFFFF, 16'hFFFF);
      plan_phase(20);
      drain();
      set_limits(16'($urandom_range(20, 60)), 16'($urandom_range(8, 20)),
                 16'($urandom_range(0, 40)));
      plan_phase(20);
      drain();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
